[rtl/odd_even_transposition_sorter_core_assert.svh]
// Assertion macros used by the checker file of the sorter.
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_CORE_ASSERT_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define OETS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define OETS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter assertion failed");

`endif

[rtl/oets_pkg.sv]
// Shared constants, types and control codes of the odd-even transposition sorter.
package oets_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 32;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT_UP,
        OP_COMPARE,
        OP_SHIFT_DOWN
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic               parity;
        logic [CNT_W-1:0]   count;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

endpackage

[rtl/oets_cell.sv]
// One sorter cell: holds one element and exchanges it with its neighbors.
module oets_cell (
    input  logic                                i_clk,
    input  oets_pkg::t_cell_ctrl                i_ctrl,
    input  logic [oets_pkg::IDX_W-1:0]          i_index,
    input  logic signed [oets_pkg::VAL_W-1:0]   i_left,
    input  logic signed [oets_pkg::VAL_W-1:0]   i_right,
    output logic signed [oets_pkg::VAL_W-1:0]   o_val
);

    logic signed [oets_pkg::VAL_W-1:0] r_val;
    logic signed [oets_pkg::VAL_W-1:0] n_val;
    logic [oets_pkg::CNT_W-1:0]        w_index;
    logic                              w_lower;
    logic                              w_upper;

    assign w_index = oets_pkg::CNT_W'(i_index);

    // A cell is the low end of a pair when its index parity matches the phase,
    // and the high end otherwise; both ends must lie inside the stored set.
    assign w_lower = (i_index[0] == i_ctrl.parity) &&
                     ((w_index + oets_pkg::CNT_W'(1)) < i_ctrl.count);
    assign w_upper = (i_index[0] != i_ctrl.parity) &&
                     (w_index != '0) && (w_index < i_ctrl.count);

    always_comb begin
        n_val = r_val;
        case (i_ctrl.op)
            oets_pkg::OP_SHIFT_UP: begin
                n_val = i_left;
            end
            oets_pkg::OP_SHIFT_DOWN: begin
                n_val = i_right;
            end
            oets_pkg::OP_COMPARE: begin
                if (w_lower && (r_val > i_right)) begin
                    n_val = i_right;
                end else if (w_upper && (i_left > r_val)) begin
                    n_val = i_left;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

[rtl/odd_even_transposition_sorter_core.sv]
// Odd-even transposition sorter: collects a set of signed 32-bit values and
// returns them in ascending signed order. The block holds up to 64 values in a
// row of identical cells. A set of N values takes N input beats (one per
// cycle unless the input channel stalls; values shift into the row), then one
// compare-exchange phase per stored value (starting with the odd phase), then
// one output beat per stored value. In any given cycle the single cell row
// either shifts, runs one phase, or shifts out, never two at once. The input
// channel stalls from the cycle after the final beat of a set until its last
// result has been taken. Values arriving when 64 are already held are thrown
// away, and every result of that set then carries the dropped flag. The
// final value of a set always ends the set, stored or not.
module odd_even_transposition_sorter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [oets_pkg::VAL_W-1:0]   i_value_in,
    input  logic                                i_last_in,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [oets_pkg::VAL_W-1:0]   o_value_out,
    output logic                                o_last_out,
    output logic                                o_dropped
);

    oets_pkg::t_state           r_state;
    oets_pkg::t_state           n_state;
    logic [oets_pkg::CNT_W-1:0] r_count;
    logic [oets_pkg::CNT_W-1:0] n_count;
    logic [oets_pkg::CNT_W-1:0] r_phase;
    logic [oets_pkg::CNT_W-1:0] n_phase;
    logic                       r_parity;
    logic                       n_parity;
    logic                       r_ovf;
    logic                       n_ovf;
    oets_pkg::t_cell_ctrl       w_ctrl;
    logic                       w_room;

    // Outputs of the cells; the extra slot feeds the right input of the top cell.
    logic signed [oets_pkg::VAL_W-1:0] w_chain [0:oets_pkg::MAX_ITEMS];

    assign w_room = (r_count < oets_pkg::CNT_W'(oets_pkg::MAX_ITEMS));

    // Sequencer: loading, sorting phases, then draining the row from cell 0.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_phase       = r_phase;
        n_parity      = r_parity;
        n_ovf         = r_ovf;
        w_ctrl.op     = oets_pkg::OP_HOLD;
        w_ctrl.parity = r_parity;
        w_ctrl.count  = r_count;
        o_in_stall    = 1'b1;
        o_out_valid   = 1'b0;
        case (r_state)
            oets_pkg::ST_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (w_room) begin
                        w_ctrl.op = oets_pkg::OP_SHIFT_UP;
                        n_count   = r_count + oets_pkg::CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_in) begin
                        // One phase per stored value, odd phase first.
                        n_state  = oets_pkg::ST_SORT;
                        n_phase  = w_room ? (r_count + oets_pkg::CNT_W'(1)) : r_count;
                        n_parity = 1'b1;
                    end
                end
            end
            oets_pkg::ST_SORT: begin
                w_ctrl.op = oets_pkg::OP_COMPARE;
                n_parity  = ~r_parity;
                n_phase   = r_phase - oets_pkg::CNT_W'(1);
                if (r_phase == oets_pkg::CNT_W'(1)) begin
                    n_state = oets_pkg::ST_EMIT;
                end
            end
            oets_pkg::ST_EMIT: begin
                // Cell 0 holds the smallest remaining value and acts as the
                // output register; each taken beat shifts the row down by one.
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    w_ctrl.op = oets_pkg::OP_SHIFT_DOWN;
                    n_count   = r_count - oets_pkg::CNT_W'(1);
                    if (r_count == oets_pkg::CNT_W'(1)) begin
                        n_state = oets_pkg::ST_LOAD;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = oets_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= oets_pkg::ST_LOAD;
            r_count  <= '0;
            r_phase  <= '0;
            r_parity <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_phase  <= n_phase;
            r_parity <= n_parity;
            r_ovf    <= n_ovf;
        end
    end

    assign w_chain[oets_pkg::MAX_ITEMS] = '0;

    // The cell row. New values enter at cell 0 and push the row upward.
    for (genvar g = 0; g < oets_pkg::MAX_ITEMS; g++) begin : g_cell
        if (g == 0) begin : g_first
            oets_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_index (oets_pkg::IDX_W'(g)),
                .i_left  (i_value_in),
                .i_right (w_chain[g+1]),
                .o_val   (w_chain[g])
            );
        end else begin : g_rest
            oets_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_index (oets_pkg::IDX_W'(g)),
                .i_left  (w_chain[g-1]),
                .i_right (w_chain[g+1]),
                .o_val   (w_chain[g])
            );
        end
    end

    assign o_value_out = w_chain[0];
    assign o_last_out  = (r_count == oets_pkg::CNT_W'(1));
    assign o_dropped   = r_ovf;

endmodule

[rtl/oets_checker.sv]
// Port-level checker of the sorter, bound to the top level.
`include "odd_even_transposition_sorter_core_assert.svh"

module oets_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic signed [oets_pkg::VAL_W-1:0]   i_value_in,
    input  logic                                i_last_in,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [oets_pkg::VAL_W-1:0]   o_value_out,
    input  logic                                o_last_out,
    input  logic                                o_dropped
);

    logic w_out_take;
    logic w_out_hold;
    logic w_in_hold;

    assign w_out_take = o_out_valid && !i_out_stall;
    assign w_out_hold = o_out_valid && i_out_stall;
    assign w_in_hold  = i_in_valid && o_in_stall;

    // A stalled input beat is offered again unchanged.
    `OETS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, w_in_hold,
        i_in_valid && $stable(i_value_in) && $stable(i_last_in))

    // A stalled result stays on the port unchanged.
    `OETS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_hold,
        o_out_valid && $stable(o_value_out) && $stable(o_last_out) && $stable(o_dropped))

    // No input beat is taken while results are being delivered.
    `OETS_ASSERT_NOW(a_no_in_during_out, i_clk, i_rst_n, o_out_valid, o_in_stall)

    // Results of one set follow each other without a gap and keep the drop flag.
    `OETS_ASSERT_NEXT(a_set_contiguous, i_clk, i_rst_n, w_out_take && !o_last_out,
        o_out_valid && (o_dropped == $past(o_dropped)))

    // After the final result the block goes back to taking input.
    `OETS_ASSERT_NEXT(a_set_done, i_clk, i_rst_n, w_out_take && o_last_out,
        !o_out_valid && !o_in_stall)

endmodule

bind odd_even_transposition_sorter_core oets_checker u_oets_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_value_in  (i_value_in),
    .i_last_in   (i_last_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value_out (o_value_out),
    .o_last_out  (o_last_out),
    .o_dropped   (o_dropped)
);
